/* rtl/c65ex_pkg.sv */
package c65ex_pkg;

    typedef enum logic [5:0] {
        OP_LDA   = 6'd0,
        OP_LDX   = 6'd1,
        OP_LDY   = 6'd2,
        OP_STA   = 6'd3,
        OP_STX   = 6'd4,
        OP_STY   = 6'd5,
        OP_TAX   = 6'd6,
        OP_TAY   = 6'd7,
        OP_TXA   = 6'd8,
        OP_TYA   = 6'd9,
        OP_PHA   = 6'd10,
        OP_PHP   = 6'd11,
        OP_PLA   = 6'd12,
        OP_PLP   = 6'd13,
        OP_AND   = 6'd14,
        OP_EOR   = 6'd15,
        OP_ORA   = 6'd16,
        OP_BIT   = 6'd17,
        OP_ADC   = 6'd18,
        OP_SBC   = 6'd19,
        OP_CMP   = 6'd20,
        OP_CPX   = 6'd21,
        OP_CPY   = 6'd22,
        OP_INC   = 6'd23,
        OP_INX   = 6'd24,
        OP_INY   = 6'd25,
        OP_DEC   = 6'd26,
        OP_DEX   = 6'd27,
        OP_DEY   = 6'd28,
        OP_ASL_A = 6'd29,
        OP_LSR_A = 6'd30,
        OP_ROL_A = 6'd31,
        OP_ROR_A = 6'd32,
        OP_ASL_M = 6'd33,
        OP_LSR_M = 6'd34,
        OP_ROL_M = 6'd35,
        OP_ROR_M = 6'd36,
        OP_CLC   = 6'd37,
        OP_CLD   = 6'd38,
        OP_CLI   = 6'd39,
        OP_CLV   = 6'd40,
        OP_SEC   = 6'd41,
        OP_SED   = 6'd42,
        OP_SEI   = 6'd43,
        OP_LAX   = 6'd44,
        OP_SAX   = 6'd45,
        OP_DCP   = 6'd46,
        OP_ISB   = 6'd47,
        OP_SLO   = 6'd48,
        OP_RLA   = 6'd49,
        OP_SRE   = 6'd50,
        OP_RRA   = 6'd51,
        OP_BCC   = 6'd52,
        OP_BCS   = 6'd53,
        OP_BEQ   = 6'd54,
        OP_BMI   = 6'd55,
        OP_BNE   = 6'd56,
        OP_BPL   = 6'd57,
        OP_BVC   = 6'd58,
        OP_BVS   = 6'd59,
        OP_NOP   = 6'd60
    } t_op;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] p;
    } t_regs;

    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [7:0] PUSH_MARK    = 8'b0011_0000;
    localparam logic [7:0] PULL_SET     = 8'b0010_0000;
    localparam logic [7:0] STATUS_RESET = 8'h34;

endpackage

/* rtl/cpu6502_execute_datapath_core.sv */
// Execute stage for decoded 6502 data operations, binary arithmetic only.
// The input channel carries one request per operation: i_mode is the
// decoded operation number and i_mem_data the operand, immediate or pulled
// stack byte. A request is taken at a rising edge where i_in_valid is high
// and o_in_stall is low.
// The output channel returns one result per request: A, X, Y and the status
// byte after the operation, a memory write byte with its enable, and the
// branch condition. It is taken where o_out_valid is high and i_out_stall
// is low.
// A taken request is held in the input register, and the ALU result with
// the new register file is captured from there into the output register,
// which drives the result outputs.
// One request per cycle is sustained while the receiver does not stall; the
// feedback from the register file through the single ALU pass sets that rate.
// When the receiver stalls, the output holds and the input register keeps
// its request, so o_in_stall rises once both stages are full.
// Synchronous reset empties both stages and sets A, X and Y to zero and the
// status byte to 0x34.
module cpu6502_execute_datapath_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [5:0] i_mode,
    input  logic [7:0] i_mem_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_acc_out,
    output logic [7:0] o_x_out,
    output logic [7:0] o_y_out,
    output logic [7:0] o_flags_out,
    output logic [7:0] o_write_data,
    output logic       o_write_enable,
    output logic       o_branch_taken
);

    logic               r_in_valid;
    c65ex_pkg::t_op     r_mode;
    logic [7:0]         r_mem;
    c65ex_pkg::t_regs   r_regs;
    logic               r_out_valid;
    logic [7:0]         r_wdata;
    logic               r_wen;
    logic               r_taken;

    c65ex_pkg::t_regs   n_regs;
    logic [7:0]         n_wdata;
    logic               n_wen;
    logic               n_taken;
    logic               out_adv;
    logic               in_take;
    logic               exec;

    c65ex_alu u_alu (
        .i_op    (r_mode),
        .i_mem   (r_mem),
        .i_regs  (r_regs),
        .o_regs  (n_regs),
        .o_wdata (n_wdata),
        .o_wen   (n_wen),
        .o_taken (n_taken)
    );

    assign out_adv    = ~r_out_valid | ~i_out_stall;
    assign exec       = r_in_valid & out_adv;
    assign o_in_stall = r_in_valid & ~out_adv;
    assign in_take    = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_regs      <= '{acc: 8'd0, x: 8'd0, y: 8'd0, p: c65ex_pkg::STATUS_RESET};
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (exec) begin
                r_regs <= n_regs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mode <= c65ex_pkg::t_op'(i_mode);
            r_mem  <= i_mem_data;
        end
        if (exec) begin
            r_wdata <= n_wdata;
            r_wen   <= n_wen;
            r_taken <= n_taken;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_acc_out      = r_regs.acc;
    assign o_x_out        = r_regs.x;
    assign o_y_out        = r_regs.y;
    assign o_flags_out    = r_regs.p;
    assign o_write_data   = r_wdata;
    assign o_write_enable = r_wen;
    assign o_branch_taken = r_taken;

endmodule

/* rtl/c65ex_alu.sv */
module c65ex_alu (
    input  c65ex_pkg::t_op   i_op,
    input  logic [7:0]       i_mem,
    input  c65ex_pkg::t_regs i_regs,
    output c65ex_pkg::t_regs o_regs,
    output logic [7:0]       o_wdata,
    output logic             o_wen,
    output logic             o_taken
);

    logic [7:0] acc;
    logic [7:0] p;
    logic       cin;
    logic       add_cin;
    logic       rot;
    logic [7:0] inc_m;
    logic [7:0] dec_m;
    logic [7:0] sh_src;
    logic [7:0] shl_r;
    logic [7:0] shr_r;
    logic [7:0] add_m;
    logic [8:0] sum;
    logic [7:0] cmp_reg;
    logic [7:0] cmp_m;
    logic [8:0] diff;
    logic [7:0] zn_v;
    logic       zn_en;

    assign acc   = i_regs.acc;
    assign p     = i_regs.p;
    assign cin   = p[c65ex_pkg::FLAG_C];
    assign inc_m = i_mem + 8'd1;
    assign dec_m = i_mem - 8'd1;

    always_comb begin
        unique case (i_op)
            c65ex_pkg::OP_ROL_A, c65ex_pkg::OP_ROR_A, c65ex_pkg::OP_ROL_M,
            c65ex_pkg::OP_ROR_M, c65ex_pkg::OP_RLA, c65ex_pkg::OP_RRA: rot = 1'b1;
            default: rot = 1'b0;
        endcase
        unique case (i_op)
            c65ex_pkg::OP_ASL_A, c65ex_pkg::OP_LSR_A,
            c65ex_pkg::OP_ROL_A, c65ex_pkg::OP_ROR_A: sh_src = acc;
            default: sh_src = i_mem;
        endcase
    end

    assign shl_r = {sh_src[6:0], rot & cin};
    assign shr_r = {rot & cin, sh_src[7:1]};

    always_comb begin
        unique case (i_op)
            c65ex_pkg::OP_SBC: add_m = ~i_mem;
            c65ex_pkg::OP_ISB: add_m = ~inc_m;
            c65ex_pkg::OP_RRA: add_m = shr_r;
            default:           add_m = i_mem;
        endcase
        unique case (i_op)
            c65ex_pkg::OP_CPX: cmp_reg = i_regs.x;
            c65ex_pkg::OP_CPY: cmp_reg = i_regs.y;
            default:           cmp_reg = acc;
        endcase
        cmp_m = (i_op == c65ex_pkg::OP_DCP) ? dec_m : i_mem;
    end

    // The rotate in RRA sets carry from the memory byte before the add uses it.
    assign add_cin = (i_op == c65ex_pkg::OP_RRA) ? i_mem[0] : cin;

    assign sum  = {1'b0, acc} + {1'b0, add_m} + {8'd0, add_cin};
    assign diff = {1'b0, cmp_reg} - {1'b0, cmp_m};

    always_comb begin
        o_regs  = i_regs;
        o_wdata = 8'd0;
        o_wen   = 1'b0;
        o_taken = 1'b0;
        zn_v    = 8'd0;
        zn_en   = 1'b0;
        unique case (i_op)
            c65ex_pkg::OP_LDA, c65ex_pkg::OP_PLA: begin
                o_regs.acc = i_mem;
                zn_v = i_mem; zn_en = 1'b1;
            end
            c65ex_pkg::OP_LDX: begin
                o_regs.x = i_mem;
                zn_v = i_mem; zn_en = 1'b1;
            end
            c65ex_pkg::OP_LDY: begin
                o_regs.y = i_mem;
                zn_v = i_mem; zn_en = 1'b1;
            end
            c65ex_pkg::OP_STA, c65ex_pkg::OP_PHA: begin
                o_wdata = acc; o_wen = 1'b1;
            end
            c65ex_pkg::OP_STX: begin
                o_wdata = i_regs.x; o_wen = 1'b1;
            end
            c65ex_pkg::OP_STY: begin
                o_wdata = i_regs.y; o_wen = 1'b1;
            end
            c65ex_pkg::OP_TAX: begin
                o_regs.x = acc;
                zn_v = acc; zn_en = 1'b1;
            end
            c65ex_pkg::OP_TAY: begin
                o_regs.y = acc;
                zn_v = acc; zn_en = 1'b1;
            end
            c65ex_pkg::OP_TXA: begin
                o_regs.acc = i_regs.x;
                zn_v = i_regs.x; zn_en = 1'b1;
            end
            c65ex_pkg::OP_TYA: begin
                o_regs.acc = i_regs.y;
                zn_v = i_regs.y; zn_en = 1'b1;
            end
            c65ex_pkg::OP_PHP: begin
                o_wdata = p | c65ex_pkg::PUSH_MARK; o_wen = 1'b1;
            end
            c65ex_pkg::OP_PLP: begin
                o_regs.p = (i_mem & ~c65ex_pkg::PUSH_MARK) | c65ex_pkg::PULL_SET;
            end
            c65ex_pkg::OP_AND: begin
                o_regs.acc = acc & i_mem;
                zn_v = acc & i_mem; zn_en = 1'b1;
            end
            c65ex_pkg::OP_EOR: begin
                o_regs.acc = acc ^ i_mem;
                zn_v = acc ^ i_mem; zn_en = 1'b1;
            end
            c65ex_pkg::OP_ORA: begin
                o_regs.acc = acc | i_mem;
                zn_v = acc | i_mem; zn_en = 1'b1;
            end
            c65ex_pkg::OP_BIT: begin
                o_regs.p[c65ex_pkg::FLAG_Z] = ((acc & i_mem) == 8'd0);
                o_regs.p[c65ex_pkg::FLAG_V] = i_mem[6];
                o_regs.p[c65ex_pkg::FLAG_N] = i_mem[7];
            end
            c65ex_pkg::OP_ADC, c65ex_pkg::OP_SBC, c65ex_pkg::OP_ISB,
            c65ex_pkg::OP_RRA: begin
                o_regs.acc = sum[7:0];
                o_regs.p[c65ex_pkg::FLAG_C] = sum[8];
                o_regs.p[c65ex_pkg::FLAG_V] = (acc[7] ^ sum[7]) & (add_m[7] ^ sum[7]);
                zn_v = sum[7:0]; zn_en = 1'b1;
                if (i_op == c65ex_pkg::OP_ISB) begin
                    o_wdata = inc_m; o_wen = 1'b1;
                end else if (i_op == c65ex_pkg::OP_RRA) begin
                    o_wdata = shr_r; o_wen = 1'b1;
                end
            end
            c65ex_pkg::OP_CMP, c65ex_pkg::OP_CPX, c65ex_pkg::OP_CPY,
            c65ex_pkg::OP_DCP: begin
                o_regs.p[c65ex_pkg::FLAG_C] = ~diff[8];
                zn_v = diff[7:0]; zn_en = 1'b1;
                if (i_op == c65ex_pkg::OP_DCP) begin
                    o_wdata = dec_m; o_wen = 1'b1;
                end
            end
            c65ex_pkg::OP_INC: begin
                o_wdata = inc_m; o_wen = 1'b1;
                zn_v = inc_m; zn_en = 1'b1;
            end
            c65ex_pkg::OP_DEC: begin
                o_wdata = dec_m; o_wen = 1'b1;
                zn_v = dec_m; zn_en = 1'b1;
            end
            c65ex_pkg::OP_INX: begin
                o_regs.x = i_regs.x + 8'd1;
                zn_v = i_regs.x + 8'd1; zn_en = 1'b1;
            end
            c65ex_pkg::OP_INY: begin
                o_regs.y = i_regs.y + 8'd1;
                zn_v = i_regs.y + 8'd1; zn_en = 1'b1;
            end
            c65ex_pkg::OP_DEX: begin
                o_regs.x = i_regs.x - 8'd1;
                zn_v = i_regs.x - 8'd1; zn_en = 1'b1;
            end
            c65ex_pkg::OP_DEY: begin
                o_regs.y = i_regs.y - 8'd1;
                zn_v = i_regs.y - 8'd1; zn_en = 1'b1;
            end
            c65ex_pkg::OP_ASL_A, c65ex_pkg::OP_ROL_A: begin
                o_regs.acc = shl_r;
                o_regs.p[c65ex_pkg::FLAG_C] = sh_src[7];
                zn_v = shl_r; zn_en = 1'b1;
            end
            c65ex_pkg::OP_LSR_A, c65ex_pkg::OP_ROR_A: begin
                o_regs.acc = shr_r;
                o_regs.p[c65ex_pkg::FLAG_C] = sh_src[0];
                zn_v = shr_r; zn_en = 1'b1;
            end
            c65ex_pkg::OP_ASL_M, c65ex_pkg::OP_ROL_M: begin
                o_wdata = shl_r; o_wen = 1'b1;
                o_regs.p[c65ex_pkg::FLAG_C] = sh_src[7];
                zn_v = shl_r; zn_en = 1'b1;
            end
            c65ex_pkg::OP_LSR_M, c65ex_pkg::OP_ROR_M: begin
                o_wdata = shr_r; o_wen = 1'b1;
                o_regs.p[c65ex_pkg::FLAG_C] = sh_src[0];
                zn_v = shr_r; zn_en = 1'b1;
            end
            c65ex_pkg::OP_CLC: o_regs.p[c65ex_pkg::FLAG_C] = 1'b0;
            c65ex_pkg::OP_CLD: o_regs.p[c65ex_pkg::FLAG_D] = 1'b0;
            c65ex_pkg::OP_CLI: o_regs.p[c65ex_pkg::FLAG_I] = 1'b0;
            c65ex_pkg::OP_CLV: o_regs.p[c65ex_pkg::FLAG_V] = 1'b0;
            c65ex_pkg::OP_SEC: o_regs.p[c65ex_pkg::FLAG_C] = 1'b1;
            c65ex_pkg::OP_SED: o_regs.p[c65ex_pkg::FLAG_D] = 1'b1;
            c65ex_pkg::OP_SEI: o_regs.p[c65ex_pkg::FLAG_I] = 1'b1;
            c65ex_pkg::OP_LAX: begin
                o_regs.acc = i_mem;
                o_regs.x   = i_mem;
                zn_v = i_mem; zn_en = 1'b1;
            end
            c65ex_pkg::OP_SAX: begin
                o_wdata = acc & i_regs.x; o_wen = 1'b1;
            end
            c65ex_pkg::OP_SLO: begin
                o_wdata = shl_r; o_wen = 1'b1;
                o_regs.acc = acc | shl_r;
                o_regs.p[c65ex_pkg::FLAG_C] = sh_src[7];
                zn_v = acc | shl_r; zn_en = 1'b1;
            end
            c65ex_pkg::OP_RLA: begin
                o_wdata = shl_r; o_wen = 1'b1;
                o_regs.acc = acc & shl_r;
                o_regs.p[c65ex_pkg::FLAG_C] = sh_src[7];
                zn_v = acc & shl_r; zn_en = 1'b1;
            end
            c65ex_pkg::OP_SRE: begin
                o_wdata = shr_r; o_wen = 1'b1;
                o_regs.acc = acc ^ shr_r;
                o_regs.p[c65ex_pkg::FLAG_C] = sh_src[0];
                zn_v = acc ^ shr_r; zn_en = 1'b1;
            end
            c65ex_pkg::OP_BCC: o_taken = ~p[c65ex_pkg::FLAG_C];
            c65ex_pkg::OP_BCS: o_taken = p[c65ex_pkg::FLAG_C];
            c65ex_pkg::OP_BEQ: o_taken = p[c65ex_pkg::FLAG_Z];
            c65ex_pkg::OP_BMI: o_taken = p[c65ex_pkg::FLAG_N];
            c65ex_pkg::OP_BNE: o_taken = ~p[c65ex_pkg::FLAG_Z];
            c65ex_pkg::OP_BPL: o_taken = ~p[c65ex_pkg::FLAG_N];
            c65ex_pkg::OP_BVC: o_taken = ~p[c65ex_pkg::FLAG_V];
            c65ex_pkg::OP_BVS: o_taken = p[c65ex_pkg::FLAG_V];
            default: ;
        endcase
        if (zn_en) begin
            o_regs.p[c65ex_pkg::FLAG_Z] = (zn_v == 8'd0);
            o_regs.p[c65ex_pkg::FLAG_N] = zn_v[7];
        end
    end

endmodule

/* sim/tb_top.sv */
module tb_top;

    localparam logic [5:0] MODE_UNUSED_LO = 6'd61;
    localparam logic [5:0] MODE_UNUSED_HI = 6'd63;
    localparam int         IDLE_LIMIT     = 4000;
    localparam int         SETTLE_CYCLES  = 8;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] p;
        logic [7:0] wdata;
        logic       wen;
        logic       taken;
    } t_exec_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [5:0] i_mode = '0;
    logic [7:0] i_mem_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_acc_out;
    logic [7:0] o_x_out;
    logic [7:0] o_y_out;
    logic [7:0] o_flags_out;
    logic [7:0] o_write_data;
    logic       o_write_enable;
    logic       o_branch_taken;

    logic [7:0]   cpu_acc;
    logic [7:0]   cpu_x;
    logic [7:0]   cpu_y;
    logic [7:0]   cpu_p;
    t_exec_result expected_results[$];
    int           mismatch_count = 0;
    int           quiet_cycles = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    cpu6502_execute_datapath_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_mem_data     (i_mem_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_acc_out      (o_acc_out),
        .o_x_out        (o_x_out),
        .o_y_out        (o_y_out),
        .o_flags_out    (o_flags_out),
        .o_write_data   (o_write_data),
        .o_write_enable (o_write_enable),
        .o_branch_taken (o_branch_taken)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void set_zn(logic [7:0] v);
        cpu_p[c65ex_pkg::FLAG_Z] = (v == 8'h00);
        cpu_p[c65ex_pkg::FLAG_N] = v[7];
    endfunction

    function automatic void add_to_acc(logic [7:0] m);
        logic [8:0] sum;
        logic [7:0] r;
        sum = {1'b0, cpu_acc} + {1'b0, m} + {8'd0, cpu_p[c65ex_pkg::FLAG_C]};
        r = sum[7:0];
        cpu_p[c65ex_pkg::FLAG_C] = sum[8];
        cpu_p[c65ex_pkg::FLAG_V] = ((cpu_acc ^ r) & (m ^ r) & 8'h80) != 8'h00;
        cpu_acc = r;
        set_zn(r);
    endfunction

    function automatic void compare_reg(logic [7:0] reg_v, logic [7:0] m);
        logic [7:0] diff;
        diff = reg_v - m;
        set_zn(diff);
        cpu_p[c65ex_pkg::FLAG_C] = (reg_v >= m);
    endfunction

    function automatic logic [7:0] shift_left(logic [7:0] v, logic rotate);
        logic [7:0] r;
        r = {v[6:0], rotate & cpu_p[c65ex_pkg::FLAG_C]};
        cpu_p[c65ex_pkg::FLAG_C] = v[7];
        set_zn(r);
        return r;
    endfunction

    function automatic logic [7:0] shift_right(logic [7:0] v, logic rotate);
        logic [7:0] r;
        r = {rotate & cpu_p[c65ex_pkg::FLAG_C], v[7:1]};
        cpu_p[c65ex_pkg::FLAG_C] = v[0];
        set_zn(r);
        return r;
    endfunction

    function automatic t_exec_result execute_op(logic [5:0] op, logic [7:0] m);
        t_exec_result res;
        logic [7:0]   t;
        res = '0;
        case (op)
            c65ex_pkg::OP_LDA, c65ex_pkg::OP_PLA: begin cpu_acc = m; set_zn(m); end
            c65ex_pkg::OP_LDX: begin cpu_x = m; set_zn(m); end
            c65ex_pkg::OP_LDY: begin cpu_y = m; set_zn(m); end
            c65ex_pkg::OP_STA, c65ex_pkg::OP_PHA: begin
                res.wdata = cpu_acc; res.wen = 1'b1;
            end
            c65ex_pkg::OP_STX: begin res.wdata = cpu_x; res.wen = 1'b1; end
            c65ex_pkg::OP_STY: begin res.wdata = cpu_y; res.wen = 1'b1; end
            c65ex_pkg::OP_TAX: begin cpu_x = cpu_acc; set_zn(cpu_x); end
            c65ex_pkg::OP_TAY: begin cpu_y = cpu_acc; set_zn(cpu_y); end
            c65ex_pkg::OP_TXA: begin cpu_acc = cpu_x; set_zn(cpu_acc); end
            c65ex_pkg::OP_TYA: begin cpu_acc = cpu_y; set_zn(cpu_acc); end
            c65ex_pkg::OP_PHP: begin
                res.wdata = cpu_p | c65ex_pkg::PUSH_MARK; res.wen = 1'b1;
            end
            c65ex_pkg::OP_PLP: cpu_p = (m & ~c65ex_pkg::PUSH_MARK) | c65ex_pkg::PULL_SET;
            c65ex_pkg::OP_AND: begin cpu_acc = cpu_acc & m; set_zn(cpu_acc); end
            c65ex_pkg::OP_EOR: begin cpu_acc = cpu_acc ^ m; set_zn(cpu_acc); end
            c65ex_pkg::OP_ORA: begin cpu_acc = cpu_acc | m; set_zn(cpu_acc); end
            c65ex_pkg::OP_BIT: begin
                cpu_p[c65ex_pkg::FLAG_Z] = ((cpu_acc & m) == 8'h00);
                cpu_p[c65ex_pkg::FLAG_V] = m[6];
                cpu_p[c65ex_pkg::FLAG_N] = m[7];
            end
            c65ex_pkg::OP_ADC: add_to_acc(m);
            c65ex_pkg::OP_SBC: add_to_acc(~m);
            c65ex_pkg::OP_CMP: compare_reg(cpu_acc, m);
            c65ex_pkg::OP_CPX: compare_reg(cpu_x, m);
            c65ex_pkg::OP_CPY: compare_reg(cpu_y, m);
            c65ex_pkg::OP_INC: begin
                res.wdata = m + 8'd1; res.wen = 1'b1; set_zn(res.wdata);
            end
            c65ex_pkg::OP_INX: begin cpu_x = cpu_x + 8'd1; set_zn(cpu_x); end
            c65ex_pkg::OP_INY: begin cpu_y = cpu_y + 8'd1; set_zn(cpu_y); end
            c65ex_pkg::OP_DEC: begin
                res.wdata = m - 8'd1; res.wen = 1'b1; set_zn(res.wdata);
            end
            c65ex_pkg::OP_DEX: begin cpu_x = cpu_x - 8'd1; set_zn(cpu_x); end
            c65ex_pkg::OP_DEY: begin cpu_y = cpu_y - 8'd1; set_zn(cpu_y); end
            c65ex_pkg::OP_ASL_A: cpu_acc = shift_left(cpu_acc, 1'b0);
            c65ex_pkg::OP_LSR_A: cpu_acc = shift_right(cpu_acc, 1'b0);
            c65ex_pkg::OP_ROL_A: cpu_acc = shift_left(cpu_acc, 1'b1);
            c65ex_pkg::OP_ROR_A: cpu_acc = shift_right(cpu_acc, 1'b1);
            c65ex_pkg::OP_ASL_M: begin res.wdata = shift_left(m, 1'b0); res.wen = 1'b1; end
            c65ex_pkg::OP_LSR_M: begin res.wdata = shift_right(m, 1'b0); res.wen = 1'b1; end
            c65ex_pkg::OP_ROL_M: begin res.wdata = shift_left(m, 1'b1); res.wen = 1'b1; end
            c65ex_pkg::OP_ROR_M: begin res.wdata = shift_right(m, 1'b1); res.wen = 1'b1; end
            c65ex_pkg::OP_CLC: cpu_p[c65ex_pkg::FLAG_C] = 1'b0;
            c65ex_pkg::OP_CLD: cpu_p[c65ex_pkg::FLAG_D] = 1'b0;
            c65ex_pkg::OP_CLI: cpu_p[c65ex_pkg::FLAG_I] = 1'b0;
            c65ex_pkg::OP_CLV: cpu_p[c65ex_pkg::FLAG_V] = 1'b0;
            c65ex_pkg::OP_SEC: cpu_p[c65ex_pkg::FLAG_C] = 1'b1;
            c65ex_pkg::OP_SED: cpu_p[c65ex_pkg::FLAG_D] = 1'b1;
            c65ex_pkg::OP_SEI: cpu_p[c65ex_pkg::FLAG_I] = 1'b1;
            c65ex_pkg::OP_LAX: begin cpu_acc = m; cpu_x = m; set_zn(m); end
            c65ex_pkg::OP_SAX: begin res.wdata = cpu_acc & cpu_x; res.wen = 1'b1; end
            c65ex_pkg::OP_DCP: begin
                t = m - 8'd1;
                res.wdata = t;
                res.wen = 1'b1;
                compare_reg(cpu_acc, t);
            end
            c65ex_pkg::OP_ISB: begin
                t = m + 8'd1;
                res.wdata = t;
                res.wen = 1'b1;
                add_to_acc(~t);
            end
            c65ex_pkg::OP_SLO: begin
                t = shift_left(m, 1'b0);
                res.wdata = t;
                res.wen = 1'b1;
                cpu_acc = cpu_acc | t;
                set_zn(cpu_acc);
            end
            c65ex_pkg::OP_RLA: begin
                t = shift_left(m, 1'b1);
                res.wdata = t;
                res.wen = 1'b1;
                cpu_acc = cpu_acc & t;
                set_zn(cpu_acc);
            end
            c65ex_pkg::OP_SRE: begin
                t = shift_right(m, 1'b0);
                res.wdata = t;
                res.wen = 1'b1;
                cpu_acc = cpu_acc ^ t;
                set_zn(cpu_acc);
            end
            c65ex_pkg::OP_RRA: begin
                t = shift_right(m, 1'b1);
                res.wdata = t;
                res.wen = 1'b1;
                add_to_acc(t);
            end
            c65ex_pkg::OP_BCC: res.taken = ~cpu_p[c65ex_pkg::FLAG_C];
            c65ex_pkg::OP_BCS: res.taken = cpu_p[c65ex_pkg::FLAG_C];
            c65ex_pkg::OP_BEQ: res.taken = cpu_p[c65ex_pkg::FLAG_Z];
            c65ex_pkg::OP_BMI: res.taken = cpu_p[c65ex_pkg::FLAG_N];
            c65ex_pkg::OP_BNE: res.taken = ~cpu_p[c65ex_pkg::FLAG_Z];
            c65ex_pkg::OP_BPL: res.taken = ~cpu_p[c65ex_pkg::FLAG_N];
            c65ex_pkg::OP_BVC: res.taken = ~cpu_p[c65ex_pkg::FLAG_V];
            c65ex_pkg::OP_BVS: res.taken = cpu_p[c65ex_pkg::FLAG_V];
            default: ;
        endcase
        res.acc = cpu_acc;
        res.x = cpu_x;
        res.y = cpu_y;
        res.p = cpu_p;
        return res;
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input logic [5:0] op, input logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_mode = op;
        i_mem_data = data;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(execute_op(op, data));
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_data();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return ($urandom_range(1) != 0) ? 8'h80 : 8'h7F;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic test_directed();
        send_request(c65ex_pkg::OP_LDA, 8'h00);
        send_request(c65ex_pkg::OP_LDA, 8'hFF);
        send_request(c65ex_pkg::OP_PHP, 8'h00);
        send_request(c65ex_pkg::OP_PLP, 8'hFF);
        send_request(c65ex_pkg::OP_PHP, 8'h00);
        send_request(c65ex_pkg::OP_PLP, 8'h00);
        send_request(c65ex_pkg::OP_LDX, 8'h80);
        send_request(c65ex_pkg::OP_LDY, 8'h7F);
        send_request(c65ex_pkg::OP_CPX, 8'h80);
        send_request(c65ex_pkg::OP_CPY, 8'h80);
        send_request(c65ex_pkg::OP_LDA, 8'h7F);
        send_request(c65ex_pkg::OP_ADC, 8'h01);
        send_request(c65ex_pkg::OP_SBC, 8'hFF);
        send_request(c65ex_pkg::OP_SEC, 8'h00);
        send_request(c65ex_pkg::OP_SBC, 8'h01);
        send_request(c65ex_pkg::OP_DCP, 8'h00);
        send_request(c65ex_pkg::OP_ISB, 8'hFF);
        send_request(c65ex_pkg::OP_SLO, 8'h80);
        send_request(c65ex_pkg::OP_RLA, 8'hFF);
        send_request(c65ex_pkg::OP_SRE, 8'h01);
        send_request(c65ex_pkg::OP_RRA, 8'hFF);
        send_request(c65ex_pkg::OP_BIT, 8'hC0);
        send_request(c65ex_pkg::OP_BVS, 8'h00);
        send_request(MODE_UNUSED_LO, 8'hFF);
        send_request(MODE_UNUSED_HI, 8'hAA);
        send_request(c65ex_pkg::OP_NOP, 8'h55);
    endtask

    task automatic test_random_ops(input int count);
        repeat (count) send_request(6'($urandom_range(63)), pick_data());
    endtask

    // The sender holds off until every outstanding request has produced its result.
    task automatic test_drain_pause();
        repeat (4) begin
            test_random_ops(20);
            drain_results();
        end
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch on %s: expected %02h, got %02h", what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_exec_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("result with no request outstanding");
                end
            end else begin
                want = expected_results.pop_front();
                if (o_acc_out !== want.acc) report_mismatch("acc", want.acc, o_acc_out);
                if (o_x_out !== want.x) report_mismatch("x", want.x, o_x_out);
                if (o_y_out !== want.y) report_mismatch("y", want.y, o_y_out);
                if (o_flags_out !== want.p) report_mismatch("flags", want.p, o_flags_out);
                if (o_write_data !== want.wdata) begin
                    report_mismatch("write_data", want.wdata, o_write_data);
                end
                if (o_write_enable !== want.wen) begin
                    report_mismatch("write_enable", {7'd0, want.wen}, {7'd0, o_write_enable});
                end
                if (o_branch_taken !== want.taken) begin
                    report_mismatch("branch_taken", {7'd0, want.taken}, {7'd0, o_branch_taken});
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("cpu6502_execute_datapath_core test failed");
            $finish;
        end
    end

    initial begin
        cpu_acc = 8'h00;
        cpu_x = 8'h00;
        cpu_y = 8'h00;
        cpu_p = c65ex_pkg::STATUS_RESET;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 26;
        recv_stall_pct = 52;
        test_directed();
        test_random_ops(500);
        test_drain_pause();

        send_idle_pct = 52;
        recv_stall_pct = 26;
        test_random_ops(520);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_ops(520);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("cpu6502_execute_datapath_core test passed");
        end else begin
            $display("cpu6502_execute_datapath_core test failed");
        end
        $finish;
    end
endmodule
